// File: src/i2cm_pkg.sv
// i2cm_pkg: shared types and constants for the I2C register access master.
// Used by every module of the block; depends on nothing.

package i2cm_pkg;

    // Largest burst length accepted by default.
    localparam int READ_LEN_MAX_DEF = 255;

    // Configuration register indexes.
    localparam int          CFG_IDX_W      = 2;
    localparam logic [1:0]  CFG_DEV_ADDR   = 2'd0;
    localparam logic [1:0]  CFG_PHASE_TCKS = 2'd1;
    localparam logic [1:0]  CFG_ACK_TMO    = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  DEV_ADDR_RST   = 8'd230;
    localparam logic [7:0]  PHASE_TCKS_RST = 8'd5;
    localparam logic [7:0]  ACK_TMO_RST    = 8'd250;

    // Command codes.
    localparam logic [1:0]  FUNC_NONE  = 2'd0;
    localparam logic [1:0]  FUNC_WRITE = 2'd1;
    localparam logic [1:0]  FUNC_READ  = 2'd2;
    localparam logic [1:0]  FUNC_WAKE  = 2'd3;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] phase_ticks;
        logic [7:0] ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] reg_addr;
        logic [7:0] wr_data;
        logic [7:0] read_len;
        logic       sda_in;
    } tick_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic [7:0] rd_data;
        logic       rd_valid;
        logic       rd_last;
        logic       done_res;
        logic       nack_error;
        logic       busy_res;
    } res_t;

endpackage

// File: src/i2cm_cfg.sv
// i2cm_cfg: configuration register file (device address, phase length, ack timeout).
// Depends on i2cm_pkg.

module i2cm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_wr_data,
    output i2cm_pkg::cfg_t                 cfg
);

    i2cm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_addr    <= i2cm_pkg::DEV_ADDR_RST;
            cfg_reg.phase_ticks <= i2cm_pkg::PHASE_TCKS_RST;
            cfg_reg.ack_timeout <= i2cm_pkg::ACK_TMO_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                i2cm_pkg::CFG_DEV_ADDR:   cfg_reg.dev_addr    <= cfg_wr_data;
                i2cm_pkg::CFG_PHASE_TCKS: cfg_reg.phase_ticks <= cfg_wr_data;
                i2cm_pkg::CFG_ACK_TMO:    cfg_reg.ack_timeout <= cfg_wr_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/i2cm_seq.sv
// i2cm_seq: bus sequencer state and its one-tick next-state / output logic.
// Depends on i2cm_pkg.

module i2cm_seq #(
    parameter int READ_LEN_MAX = i2cm_pkg::READ_LEN_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  i2cm_pkg::tick_t item,
    input  i2cm_pkg::cfg_t  cfg,
    output i2cm_pkg::res_t  res
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ST_HI  = 5'd1;
    localparam logic [4:0] S_ST_LO  = 5'd2;
    localparam logic [4:0] S_TX_LO  = 5'd3;
    localparam logic [4:0] S_TX_HI  = 5'd4;
    localparam logic [4:0] S_ACK_LO = 5'd5;
    localparam logic [4:0] S_ACK_HI = 5'd6;
    localparam logic [4:0] S_RS_LO  = 5'd7;
    localparam logic [4:0] S_RX_LO  = 5'd8;
    localparam logic [4:0] S_RX_HI  = 5'd9;
    localparam logic [4:0] S_MA_LO  = 5'd10;
    localparam logic [4:0] S_MA_HI  = 5'd11;
    localparam logic [4:0] S_SP_LO  = 5'd12;
    localparam logic [4:0] S_SP_HI  = 5'd13;
    localparam logic [4:0] S_SP_END = 5'd14;

    localparam logic [1:0] STG_ADDR_W = 2'd0;
    localparam logic [1:0] STG_REG    = 2'd1;
    localparam logic [1:0] STG_DATA   = 2'd2;
    localparam logic [1:0] STG_ADDR_R = 2'd3;

    localparam logic [7:0] LEN_CAP = 8'((READ_LEN_MAX > 255) ? 255 : READ_LEN_MAX);

    logic [4:0]  state_reg,  state_next;
    logic [7:0]  phase_reg,  phase_next;
    logic [3:0]  bit_reg,    bit_next;
    logic [7:0]  shift_reg,  shift_next;
    logic [7:0]  left_reg,   left_next;
    logic [7:0]  ackw_reg,   ackw_next;
    logic [17:0] cmd_reg,    cmd_next;
    logic [1:0]  stage_reg,  stage_next;
    logic        aerr_reg,   aerr_next;

    logic [7:0]  phase_len;
    logic        pd;
    logic [7:0]  len_clip;
    logic [7:0]  shift_in;
    logic [3:0]  bit_inc;
    logic [7:0]  left_dec;
    logic        ack_ok;
    logic        ack_miss;

    // Zero phase length behaves as one tick.
    assign phase_len = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
    assign pd        = ({1'b0, phase_reg} + 9'd1) >= {1'b0, phase_len};
    assign len_clip  = (32'(item.read_len) > READ_LEN_MAX) ? LEN_CAP : item.read_len;
    assign shift_in  = {shift_reg[6:0], item.sda_in};
    assign bit_inc   = bit_reg + 4'd1;
    assign left_dec  = (left_reg != 8'd0) ? left_reg - 8'd1 : 8'd0;
    assign ack_ok    = !item.sda_in && pd;
    assign ack_miss  = item.sda_in && (ackw_reg >= cfg.ack_timeout);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        ackw_next  = ackw_reg;
        cmd_next   = cmd_reg;
        stage_next = stage_reg;
        aerr_next  = aerr_reg;

        res              = '0;
        res.scl_level    = 1'b1;
        res.busy_res     = (state_reg != S_IDLE);

        // Line levels come from the state at the start of the tick.
        case (state_reg)
            S_ST_LO:  res.sda_pull_low = 1'b1;
            S_TX_LO:
            begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = !shift_reg[7];
            end
            S_TX_HI:  res.sda_pull_low = !shift_reg[7];
            S_ACK_LO, S_RS_LO, S_RX_LO: res.scl_level = 1'b0;
            S_MA_LO:
            begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = (left_reg > 8'd1);
            end
            S_MA_HI:  res.sda_pull_low = (left_reg > 8'd1);
            S_SP_LO:
            begin
                res.scl_level    = 1'b0;
                res.sda_pull_low = 1'b1;
            end
            S_SP_HI:  res.sda_pull_low = 1'b1;
            default: ;
        endcase

        // Timed states advance the phase counter unless the phase ends.
        if (state_reg != S_IDLE && !pd)
            phase_next = phase_reg + 8'd1;

        case (state_reg)
            S_IDLE:
            begin
                phase_next = phase_reg;
                if (item.func != i2cm_pkg::FUNC_NONE)
                begin
                    cmd_next   = {item.func, item.reg_addr, item.wr_data};
                    left_next  = len_clip;
                    stage_next = STG_ADDR_W;
                    aerr_next  = 1'b0;
                    ackw_next  = 8'd0;
                    shift_next = cfg.dev_addr;
                    bit_next   = 4'd0;
                    state_next = S_ST_HI;
                    phase_next = 8'd0;
                end
            end
            S_ST_HI:  if (pd) begin state_next = S_ST_LO;  phase_next = 8'd0; end
            S_ST_LO:  if (pd) begin state_next = S_TX_LO;  phase_next = 8'd0; end
            S_TX_LO:  if (pd) begin state_next = S_TX_HI;  phase_next = 8'd0; end
            S_TX_HI:
            begin
                if (pd)
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bit_next   = bit_inc;
                    phase_next = 8'd0;
                    if (bit_inc < 4'd8)
                        state_next = S_TX_LO;
                    else if (cmd_reg[17:16] == i2cm_pkg::FUNC_WAKE && stage_reg == STG_ADDR_W)
                        state_next = S_SP_LO;   // wake-up: no ack clock
                    else
                        state_next = S_ACK_LO;
                end
            end
            S_ACK_LO:
            begin
                if (pd)
                begin
                    ackw_next  = 8'd0;
                    state_next = S_ACK_HI;
                    phase_next = 8'd0;
                end
            end
            S_ACK_HI:
            begin
                if (item.sda_in && !ack_miss)
                    ackw_next = ackw_reg + 8'd1;
                if (ack_ok || ack_miss)
                begin
                    phase_next = 8'd0;
                    case (stage_reg)
                        STG_ADDR_W:
                        begin
                            if (ack_miss)
                            begin
                                aerr_next  = 1'b1;
                                state_next = S_SP_LO;
                            end
                            else
                            begin
                                stage_next = STG_REG;
                                shift_next = cmd_reg[15:8];
                                bit_next   = 4'd0;
                                state_next = S_TX_LO;
                            end
                        end
                        STG_REG:
                        begin
                            bit_next = 4'd0;
                            if (cmd_reg[17:16] == i2cm_pkg::FUNC_WRITE)
                            begin
                                stage_next = STG_DATA;
                                shift_next = cmd_reg[7:0];
                                state_next = S_TX_LO;
                            end
                            else
                            begin
                                stage_next = STG_ADDR_R;
                                shift_next = cfg.dev_addr | 8'h01;
                                state_next = S_RS_LO;
                            end
                        end
                        STG_DATA: state_next = S_SP_LO;
                        default:
                        begin
                            if (left_reg == 8'd0)
                                state_next = S_SP_LO;
                            else
                            begin
                                shift_next = 8'd0;
                                bit_next   = 4'd0;
                                state_next = S_RX_LO;
                            end
                        end
                    endcase
                end
            end
            S_RS_LO:  if (pd) begin state_next = S_ST_HI;  phase_next = 8'd0; end
            S_RX_LO:  if (pd) begin state_next = S_RX_HI;  phase_next = 8'd0; end
            S_RX_HI:
            begin
                if (pd)
                begin
                    shift_next = shift_in;
                    bit_next   = bit_inc;
                    phase_next = 8'd0;
                    if (bit_inc < 4'd8)
                        state_next = S_RX_LO;
                    else
                    begin
                        res.rd_data  = shift_in;
                        res.rd_valid = 1'b1;
                        res.rd_last  = (left_reg == 8'd1);
                        state_next   = S_MA_LO;
                    end
                end
            end
            S_MA_LO:  if (pd) begin state_next = S_MA_HI;  phase_next = 8'd0; end
            S_MA_HI:
            begin
                if (pd)
                begin
                    left_next  = left_dec;
                    phase_next = 8'd0;
                    if (left_dec == 8'd0)
                        state_next = S_SP_LO;
                    else
                    begin
                        shift_next = 8'd0;
                        bit_next   = 4'd0;
                        state_next = S_RX_LO;
                    end
                end
            end
            S_SP_LO:  if (pd) begin state_next = S_SP_HI;  phase_next = 8'd0; end
            S_SP_HI:  if (pd) begin state_next = S_SP_END; phase_next = 8'd0; end
            S_SP_END:
            begin
                if (pd)
                begin
                    res.done_res   = 1'b1;
                    res.nack_error = aerr_reg;
                    state_next     = S_IDLE;
                    phase_next     = 8'd0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                phase_next = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 8'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            left_reg  <= 8'd0;
            ackw_reg  <= 8'd0;
            cmd_reg   <= 18'd0;
            stage_reg <= STG_ADDR_W;
            aerr_reg  <= 1'b0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            ackw_reg  <= ackw_next;
            cmd_reg   <= cmd_next;
            stage_reg <= stage_next;
            aerr_reg  <= aerr_next;
        end
    end

    // A transaction only ends from a busy state.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |-> res.busy_res)
        else $error("done raised while idle");

    // An address error is only reported with done.
    a_nack_done: assert property (@(posedge clk) disable iff (!rst_n)
        res.nack_error |-> res.done_res)
        else $error("nack_error without done");

    // After a received byte the master acknowledge phase follows.
    a_rx_then_ma: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.rd_valid |=> state_reg == S_MA_LO)
        else $error("byte received but no master ack phase");

    // Bit counter never runs past one byte.
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= 4'd8)
        else $error("bit counter out of range");

endmodule

// File: src/i2cm_out.sv
// i2cm_out: result register with valid/stall handshake toward the consumer.
// Depends on i2cm_pkg.

module i2cm_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  i2cm_pkg::res_t  res,
    output logic           res_valid,
    input  logic           res_stall,
    output i2cm_pkg::res_t  res_data,
    output logic           full_stall
);

    logic           valid_reg;
    i2cm_pkg::res_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (step)
            valid_reg <= 1'b1;
        else if (!res_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            data_reg <= res;
    end

    // A new tick is taken whenever the held result leaves this cycle or none is held.
    assign full_stall = valid_reg && res_stall;
    assign res_valid  = valid_reg;
    assign res_data   = data_reg;

endmodule

// File: src/i2c_master_register_access_unit.sv
// i2c_master_register_access_unit: top level of the I2C register access master.
// Depends on i2cm_pkg, i2cm_cfg, i2cm_seq and i2cm_out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   tick    | in        | tick_valid/tick_stall| tick_data (i2cm_pkg::tick_t)
//   res     | out       | res_valid/res_stall  | res_data  (i2cm_pkg::res_t)
//   cfg     | in        | cfg_wr_en            | cfg_index, cfg_wr_data
//
// One tick transfer is taken per clock while tick_stall is low; its result is in
// the result register the next cycle. The sequencer's next-state and output
// logic between the state registers and the result register is combinational.
// tick_stall rises only while a result is held and res_stall is high.
// After rst_n the bus lines idle high, the sequencer is idle and the
// configuration registers hold their defaults.

module i2c_master_register_access_unit #(
    parameter int READ_LEN_MAX = i2cm_pkg::READ_LEN_MAX_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           tick_valid,
    output logic                           tick_stall,
    input  i2cm_pkg::tick_t                tick_data,
    output logic                           res_valid,
    input  logic                           res_stall,
    output i2cm_pkg::res_t                 res_data,
    input  logic                           cfg_wr_en,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_wr_data
);

    i2cm_pkg::cfg_t cfg;
    i2cm_pkg::res_t res;
    logic           step;

    // A tick transfer advances the sequencer by one tick.
    assign step = tick_valid && !tick_stall;

    i2cm_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    i2cm_seq #(
        .READ_LEN_MAX (READ_LEN_MAX)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (tick_data),
        .cfg   (cfg),
        .res   (res)
    );

    i2cm_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .res        (res),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .full_stall (tick_stall)
    );

endmodule

// File: sim/i2c_master_register_access_unit_tb.sv
// Self-checking bench for the I2C register access master: an in-bench bus
// sequencer model predicts every result transfer, stimulus comes from a
// directed command table, then random phases. Depends on i2cm_pkg and the top.

module i2c_master_register_access_unit_tb;

    // Sequencer states of the in-bench bus model.
    typedef enum logic [4:0] {
        SQ_IDLE, SQ_START_HI, SQ_START_LO, SQ_TX_LO, SQ_TX_HI, SQ_ACK_LO, SQ_ACK_HI,
        SQ_RS_LO, SQ_RX_LO, SQ_RX_HI, SQ_MACK_LO, SQ_MACK_HI, SQ_STOP_LO, SQ_STOP_HI,
        SQ_STOP_END
    } seq_state_e;

    // Which byte of the transaction the next acknowledge belongs to.
    typedef enum logic [1:0] {STG_ADDR_W, STG_REG, STG_DATA, STG_ADDR_R} byte_stage_e;

    // How the emulated device answers acknowledge slots.
    typedef enum logic [1:0] {RSP_ACK, RSP_NOISY, RSP_NACK_ADDR, RSP_NACK_DATA} resp_mode_e;

    // Typed check on the closing transfer of a directed command.
    typedef enum logic [1:0] {PIN_NONE, PIN_CLEAR, PIN_SET} nack_pin_e;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  reg_addr;
        logic [7:0]  wr_data;
        logic [7:0]  read_len;
        resp_mode_e  mode;
        logic        pin_idle;
        nack_pin_e   end_nack;
    } dir_row_t;

    localparam int N_DIR       = 14;
    localparam int N_PHASES    = 8;
    localparam int PHASE_TICKS = 125;
    localparam int LONG_HOLD   = 40;

    // Result of any tick taken while the sequencer is idle.
    localparam i2cm_pkg::res_t BUS_IDLE_RES =
        '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

    // Directed rows run with one-tick phases and a short acknowledge timeout.
    localparam i2cm_pkg::cfg_t DIR_CFG = '{i2cm_pkg::DEV_ADDR_RST, 8'd1, 8'd4};

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            tick_valid = 1'b0;
    logic            tick_stall;
    i2cm_pkg::tick_t tick_data = '0;
    logic            res_valid;
    logic            res_stall = 1'b0;
    i2cm_pkg::res_t  res_data;
    logic            cfg_wr_en = 1'b0;
    logic [1:0]      cfg_index = i2cm_pkg::CFG_DEV_ADDR;
    logic [7:0]      cfg_wr_data = 8'h00;

    // Bus model state and its copy of the configuration registers.
    i2cm_pkg::cfg_t m_cfg;
    seq_state_e  sq;
    byte_stage_e stage;
    logic [7:0]  ph_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [7:0]  bytes_left;
    logic [7:0]  ack_wait;
    logic [17:0] cmd_lat;
    logic        addr_err;

    i2cm_pkg::res_t pending_bus_results [$];
    resp_mode_e  resp_mode = RSP_ACK;
    logic        pin_first = 1'b0;
    nack_pin_e   pin_nack = PIN_NONE;
    logic        gaps_on = 1'b1;
    logic        long_hold_req = 1'b0;

    dir_row_t       dir_rows [N_DIR];
    i2cm_pkg::cfg_t phase_cfg [N_PHASES];

    int err_cnt = 0;
    int ticks_taken = 0;
    int results_seen = 0;
    int txn_done = 0;
    int txn_nack = 0;
    int bytes_read = 0;

    i2c_master_register_access_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .tick_data   (tick_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bus sequencer model
    // ------------------------------------------------------------------

    function automatic void enter(seq_state_e s);
        sq = s;
        ph_cnt = 8'd0;
    endfunction

    function automatic void load_byte(seq_state_e s, logic [7:0] b);
        shreg = b;
        bit_cnt = 4'd0;
        enter(s);
    endfunction

    // True once the current SCL phase has lasted its programmed length;
    // a phase length of zero behaves as one tick.
    function automatic logic phase_elapsed();
        logic [8:0] lim;
        lim = (m_cfg.phase_ticks == 8'd0) ? 9'd1 : {1'b0, m_cfg.phase_ticks};
        if ({1'b0, ph_cnt} + 9'd1 >= lim)
            return 1'b1;
        ph_cnt = ph_cnt + 8'd1;
        return 1'b0;
    endfunction

    // Next step after an acknowledge slot. Only the write address byte cares
    // whether the device answered; later NACKs are simply ridden over.
    function automatic void ack_resolve(logic acked);
        case (stage)
            STG_ADDR_W:
            begin
                if (!acked)
                begin
                    addr_err = 1'b1;
                    enter(SQ_STOP_LO);
                end
                else
                begin
                    stage = STG_REG;
                    load_byte(SQ_TX_LO, cmd_lat[15:8]);
                end
            end
            STG_REG:
            begin
                if (cmd_lat[17:16] == i2cm_pkg::FUNC_WRITE)
                begin
                    stage = STG_DATA;
                    load_byte(SQ_TX_LO, cmd_lat[7:0]);
                end
                else
                begin
                    // burst read: repeated start, then the read address
                    stage = STG_ADDR_R;
                    load_byte(SQ_RS_LO, m_cfg.dev_addr | 8'h01);
                end
            end
            STG_DATA:
                enter(SQ_STOP_LO);
            default:
            begin
                if (bytes_left == 8'd0)
                    enter(SQ_STOP_LO);
                else
                    load_byte(SQ_RX_LO, 8'h00);
            end
        endcase
    endfunction

    // One tick of the bus sequencer: line levels come from the state at the
    // start of the tick, read data and done flags from the step itself.
    function automatic i2cm_pkg::res_t next_bus_result(i2cm_pkg::tick_t t);
        i2cm_pkg::res_t r;
        logic pd;
        r = BUS_IDLE_RES;
        r.busy_res = (sq != SQ_IDLE);

        case (sq)
            SQ_START_LO: r.sda_pull_low = 1'b1;
            SQ_TX_LO:
            begin
                r.scl_level = 1'b0;
                r.sda_pull_low = ~shreg[7];
            end
            SQ_TX_HI: r.sda_pull_low = ~shreg[7];
            SQ_ACK_LO, SQ_RS_LO, SQ_RX_LO: r.scl_level = 1'b0;
            SQ_MACK_LO:
            begin
                r.scl_level = 1'b0;
                r.sda_pull_low = (bytes_left > 8'd1);
            end
            SQ_MACK_HI: r.sda_pull_low = (bytes_left > 8'd1);
            SQ_STOP_LO:
            begin
                r.scl_level = 1'b0;
                r.sda_pull_low = 1'b1;
            end
            SQ_STOP_HI: r.sda_pull_low = 1'b1;
            default: ;
        endcase

        case (sq)
            SQ_IDLE:
            begin
                if (t.func != i2cm_pkg::FUNC_NONE)
                begin
                    cmd_lat = {t.func, t.reg_addr, t.wr_data};
                    bytes_left = (t.read_len > i2cm_pkg::READ_LEN_MAX_DEF) ?
                                 8'(i2cm_pkg::READ_LEN_MAX_DEF) : t.read_len;
                    stage = STG_ADDR_W;
                    addr_err = 1'b0;
                    ack_wait = 8'd0;
                    load_byte(SQ_START_HI, m_cfg.dev_addr);
                end
            end
            SQ_START_HI: if (phase_elapsed()) enter(SQ_START_LO);
            SQ_START_LO: if (phase_elapsed()) enter(SQ_TX_LO);
            SQ_TX_LO:    if (phase_elapsed()) enter(SQ_TX_HI);
            SQ_TX_HI:
            begin
                if (phase_elapsed())
                begin
                    shreg = {shreg[6:0], 1'b0};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < 4'd8)
                        enter(SQ_TX_LO);
                    else if (cmd_lat[17:16] == i2cm_pkg::FUNC_WAKE && stage == STG_ADDR_W)
                        enter(SQ_STOP_LO);   // wake-up: no acknowledge clock
                    else
                        enter(SQ_ACK_LO);
                end
            end
            SQ_ACK_LO:
            begin
                if (phase_elapsed())
                begin
                    ack_wait = 8'd0;
                    enter(SQ_ACK_HI);
                end
            end
            SQ_ACK_HI:
            begin
                pd = phase_elapsed();
                if (!t.sda_in)
                begin
                    if (pd)
                        ack_resolve(1'b1);
                end
                else if (ack_wait >= m_cfg.ack_timeout)
                    ack_resolve(1'b0);
                else
                    ack_wait = ack_wait + 8'd1;
            end
            SQ_RS_LO: if (phase_elapsed()) enter(SQ_START_HI);
            SQ_RX_LO: if (phase_elapsed()) enter(SQ_RX_HI);
            SQ_RX_HI:
            begin
                if (phase_elapsed())
                begin
                    shreg = {shreg[6:0], t.sda_in};
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt < 4'd8)
                        enter(SQ_RX_LO);
                    else
                    begin
                        r.rd_data = shreg;
                        r.rd_valid = 1'b1;
                        r.rd_last = (bytes_left == 8'd1);
                        enter(SQ_MACK_LO);
                    end
                end
            end
            SQ_MACK_LO: if (phase_elapsed()) enter(SQ_MACK_HI);
            SQ_MACK_HI:
            begin
                if (phase_elapsed())
                begin
                    if (bytes_left > 8'd0)
                        bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                        enter(SQ_STOP_LO);
                    else
                        load_byte(SQ_RX_LO, 8'h00);
                end
            end
            SQ_STOP_LO: if (phase_elapsed()) enter(SQ_STOP_HI);
            SQ_STOP_HI: if (phase_elapsed()) enter(SQ_STOP_END);
            SQ_STOP_END:
            begin
                if (phase_elapsed())
                begin
                    r.done_res = 1'b1;
                    r.nack_error = addr_err;
                    enter(SQ_IDLE);
                end
            end
            default: enter(SQ_IDLE);
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random tick payload. SDA answers acknowledge slots per the device
    // response mode of the running transaction; elsewhere it is random
    // (read data bits included).
    function automatic i2cm_pkg::tick_t rand_tick();
        i2cm_pkg::tick_t t;
        t.func = 2'($urandom_range(i2cm_pkg::FUNC_NONE, i2cm_pkg::FUNC_WAKE));
        t.reg_addr = 8'($urandom);
        t.wr_data = 8'($urandom);
        // mostly short bursts, now and then any length
        t.read_len = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
        t.sda_in = 1'($urandom);
        if (sq == SQ_ACK_HI)
        begin
            case (resp_mode)
                RSP_ACK:       t.sda_in = 1'b0;
                RSP_NOISY:     t.sda_in = ($urandom_range(0, 3) == 0);
                RSP_NACK_ADDR: t.sda_in = (stage == STG_ADDR_W);
                default:       t.sda_in = (stage != STG_ADDR_W);
            endcase
        end
        return t;
    endfunction

    // Offer one tick transfer; returns at the falling edge after acceptance.
    // Valid may drop for a random gap first, never as a reaction to stall.
    task automatic send(i2cm_pkg::tick_t t);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        tick_data <= t;
        tick_valid <= 1'b1;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sender pauses until every expected result transfer has come back.
    task automatic drain();
        tick_valid <= 1'b0;
        while (pending_bus_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Program all three registers, one write per cycle, and track them in the model.
    task automatic write_regs(i2cm_pkg::cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_index <= i2cm_pkg::CFG_DEV_ADDR;
        cfg_wr_data <= c.dev_addr;
        @(negedge clk);
        cfg_index <= i2cm_pkg::CFG_PHASE_TCKS;
        cfg_wr_data <= c.phase_ticks;
        @(negedge clk);
        cfg_index <= i2cm_pkg::CFG_ACK_TMO;
        cfg_wr_data <= c.ack_timeout;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        m_cfg = c;
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted tick, compare every accepted result
    // ------------------------------------------------------------------

    i2cm_pkg::res_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tick_valid && !tick_stall)
            begin
                want = next_bus_result(tick_data);
                ticks_taken++;
                // directed rows may pin the typed value instead
                if (pin_first)
                begin
                    want = BUS_IDLE_RES;
                    pin_first = 1'b0;
                end
                if (want.done_res && pin_nack != PIN_NONE)
                begin
                    want.nack_error = (pin_nack == PIN_SET);
                    pin_nack = PIN_NONE;
                end
                if (want.done_res)
                    txn_done++;
                if (want.nack_error)
                    txn_nack++;
                if (want.rd_valid)
                    bytes_read++;
                pending_bus_results.push_back(want);
            end
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (pending_bus_results.size() == 0)
                begin
                    $error("result transfer with no tick outstanding");
                    err_cnt++;
                end
                else
                begin
                    want = pending_bus_results.pop_front();
                    check_field("scl_level",    8'(want.scl_level),    8'(res_data.scl_level));
                    check_field("sda_pull_low", 8'(want.sda_pull_low),
                                8'(res_data.sda_pull_low));
                    check_field("rd_data",      want.rd_data,          res_data.rd_data);
                    check_field("rd_valid",     8'(want.rd_valid),     8'(res_data.rd_valid));
                    check_field("rd_last",      8'(want.rd_last),      8'(res_data.rd_last));
                    check_field("done_res",     8'(want.done_res),     8'(res_data.done_res));
                    check_field("nack_error",   8'(want.nack_error),   8'(res_data.nack_error));
                    check_field("busy_res",     8'(want.busy_res),     8'(res_data.busy_res));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request so
    // the block fills and pushes back on the tick channel.
    // ------------------------------------------------------------------

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
                res_stall <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                res_stall <= 1'b0;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        i2cm_pkg::tick_t t;
        int              counted;

        // model starts from the reset state
        m_cfg = '{i2cm_pkg::DEV_ADDR_RST, i2cm_pkg::PHASE_TCKS_RST, i2cm_pkg::ACK_TMO_RST};
        sq = SQ_IDLE;
        stage = STG_ADDR_W;
        ph_cnt = 8'd0;
        bit_cnt = 4'd0;
        shreg = 8'h00;
        bytes_left = 8'd0;
        ack_wait = 8'd0;
        cmd_lat = 18'd0;
        addr_err = 1'b0;

        // Directed commands, run with one-tick phases and a short timeout so
        // each row stays short. Each row runs its transaction to idle;
        // pin_idle types the first result, end_nack types the error flag of
        // the closing transfer.
        dir_rows = '{
            '{i2cm_pkg::FUNC_NONE,  8'h00, 8'h00, 8'h00, RSP_ACK,       1'b1, PIN_NONE},
            '{i2cm_pkg::FUNC_WRITE, 8'h00, 8'hFF, 8'h00, RSP_ACK,       1'b1, PIN_CLEAR},
            '{i2cm_pkg::FUNC_WRITE, 8'hFF, 8'h00, 8'hFF, RSP_ACK,       1'b0, PIN_CLEAR},
            '{i2cm_pkg::FUNC_WRITE, 8'h12, 8'h34, 8'h00, RSP_NACK_ADDR, 1'b1, PIN_SET},
            '{i2cm_pkg::FUNC_READ,  8'h80, 8'h00, 8'h01, RSP_ACK,       1'b0, PIN_CLEAR},
            '{i2cm_pkg::FUNC_READ,  8'h7F, 8'h00, 8'h00, RSP_ACK,       1'b0, PIN_CLEAR},
            '{i2cm_pkg::FUNC_READ,  8'h01, 8'h00, 8'h03, RSP_NACK_DATA, 1'b0, PIN_CLEAR},
            '{i2cm_pkg::FUNC_READ,  8'hFE, 8'hFF, 8'h06, RSP_ACK,       1'b1, PIN_CLEAR},
            '{i2cm_pkg::FUNC_WAKE,  8'h00, 8'h00, 8'h00, RSP_NACK_ADDR, 1'b0, PIN_CLEAR},
            '{i2cm_pkg::FUNC_READ,  8'h55, 8'hAA, 8'h02, RSP_NACK_ADDR, 1'b0, PIN_SET},
            '{i2cm_pkg::FUNC_WRITE, 8'hA5, 8'h5A, 8'h10, RSP_NACK_DATA, 1'b0, PIN_CLEAR},
            '{i2cm_pkg::FUNC_WAKE,  8'hFF, 8'hFF, 8'hFF, RSP_ACK,       1'b1, PIN_CLEAR},
            '{i2cm_pkg::FUNC_READ,  8'hC3, 8'h3C, 8'h02, RSP_NOISY,     1'b0, PIN_NONE},
            '{i2cm_pkg::FUNC_WRITE, 8'h3C, 8'hC3, 8'h04, RSP_NOISY,     1'b0, PIN_NONE}
        };

        // Register settings per random phase: all-ones and all-zeros extremes
        // (zero phase length acts as one tick), slow clocks, tight and loose
        // acknowledge timeouts, and the reset values again.
        phase_cfg = '{
            '{8'h00, 8'd1,   8'd1},
            '{8'hFF, 8'd0,   8'd0},
            '{8'h5A, 8'd2,   8'd3},
            '{8'hA5, 8'd255, 8'd255},
            '{8'h3C, 8'd1,   8'd255},
            '{8'h00, 8'd1,   8'd1},
            '{i2cm_pkg::DEV_ADDR_RST, i2cm_pkg::PHASE_TCKS_RST, i2cm_pkg::ACK_TMO_RST},
            '{8'h81, 8'd1,   8'd7}
        };
        phase_cfg[5] = '{8'($urandom), 8'($urandom_range(1, 4)), 8'($urandom)};

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_regs(DIR_CFG);

        for (int i = 0; i < N_DIR; i++)
        begin
            t = rand_tick();
            t.func = dir_rows[i].func;
            t.reg_addr = dir_rows[i].reg_addr;
            t.wr_data = dir_rows[i].wr_data;
            t.read_len = dir_rows[i].read_len;
            resp_mode = dir_rows[i].mode;
            pin_first = dir_rows[i].pin_idle;
            pin_nack = dir_rows[i].end_nack;
            send(t);
            // random commands while busy must be ignored
            while (sq != SQ_IDLE)
                send(rand_tick());
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            // registers change only with no transfer outstanding; a phase may
            // still cut into a transaction, which then runs on new settings
            drain();
            write_regs(phase_cfg[p]);

            if (p == 2)
                long_hold_req = 1'b1;
            if (p == N_PHASES - 1)
                gaps_on = 1'b0;

            counted = 0;
            while (counted < PHASE_TICKS)
            begin
                t = rand_tick();
                if (sq == SQ_IDLE && t.func != i2cm_pkg::FUNC_NONE)
                    resp_mode = ($urandom_range(0, 7) < 4) ? RSP_ACK :
                                resp_mode_e'($urandom_range(RSP_NOISY, RSP_NACK_DATA));
                // idle ticks with no command do nothing and are not counted
                if (sq != SQ_IDLE || t.func != i2cm_pkg::FUNC_NONE)
                    counted++;
                send(t);
            end
        end

        drain();
        $display("Run covered %0d tick transfers and %0d result transfers: %0d transactions",
                 ticks_taken, results_seen, txn_done);
        $display("closed (%0d on address NACK), %0d bytes read, over %0d register settings.",
                 txn_nack, bytes_read, N_PHASES + 1);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: i2c_master_register_access_unit.f
src/i2cm_pkg.sv
src/i2cm_cfg.sv
src/i2cm_seq.sv
src/i2cm_out.sv
src/i2c_master_register_access_unit.sv
sim/i2c_master_register_access_unit_tb.sv
